// ===== rtl/tuc_pkg.sv =====
// ----------------------------------------------------------------------------
// tuc_pkg
// Shared types, status codes and UTF-8 encode helpers for the UTF-16 to
// UTF-8 transcoder.
// ----------------------------------------------------------------------------
package tuc_pkg;

    localparam int UNIT_W  = 16;
    localparam int CAP_W   = 16;
    localparam int BCNT_W  = 17;
    localparam int CP_W    = 21;
    localparam int MAX_RES = 6;
    localparam int RCNT_W  = 3;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_SRC_EXH = 3'd2;
    localparam logic [2:0] ST_TGT_EXH = 3'd3;
    localparam logic [2:0] ST_SRC_ILL = 3'd4;

    localparam logic CFG_STRICT   = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    localparam logic [5:0]      SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]      SUR_LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;

    typedef struct packed {
        logic [7:0] data;
        logic       dvalid;
        logic [2:0] status;
    } tuc_res_t;

    typedef struct packed {
        logic [RCNT_W-1:0]          count;
        tuc_res_t [MAX_RES-1:0]     res;
    } tuc_group_t;

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] ch);
        logic [2:0] n;
        if (ch < 21'h80)
            n = 3'd1;
        else if (ch < 21'h800)
            n = 3'd2;
        else if (ch < 21'h10000)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

    // Bytes in slots 0..len-1, leading byte in slot 0.
    function automatic logic [3:0][7:0] utf8_bytes(input logic [CP_W-1:0] ch);
        logic [3:0][7:0] b;
        b = '0;
        unique case (utf8_len(ch))
            3'd1:
            begin
                b[0] = ch[7:0];
            end
            3'd2:
            begin
                b[0] = {3'b110, ch[10:6]};
                b[1] = {2'b10, ch[5:0]};
            end
            3'd3:
            begin
                b[0] = {4'b1110, ch[15:12]};
                b[1] = {2'b10, ch[11:6]};
                b[2] = {2'b10, ch[5:0]};
            end
            default:
            begin
                b[0] = {5'b11110, ch[20:18]};
                b[1] = {2'b10, ch[17:12]};
                b[2] = {2'b10, ch[11:6]};
                b[3] = {2'b10, ch[5:0]};
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Zero-terminated UTF-16 code unit stream in, UTF-8 bytes and string status
// out.
//
//   channel   signals                                   width
//   input     in_valid/in_ready, code_unit              16
//   output    out_valid/out_ready, out_byte,            8/1/3/1
//             byte_valid, status, last
//   config    cfg_wr_en, cfg_index, cfg_data            1/1/16
//
// One code unit per cycle enters when its results fit the output queue.
// A request waits in the input register, is encoded in one pass, and
// its results (zero to six) leave one per cycle from the result queue
// while out_ready is high. A unit giving results waits until the
// single-read output queue is free; units giving no result do not wait.
// Reset clears string state, strict mode to 1 and capacity to 65535.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [tuc_pkg::CAP_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tuc_pkg::UNIT_W-1:0]  code_unit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic [2:0]                  status,
    output logic                        last
);

    logic                        item_valid;
    logic [tuc_pkg::UNIT_W-1:0]  item_unit;
    logic                        pop;
    logic                        q_free;
    logic                        load;
    tuc_pkg::tuc_group_t         group;

    assign load = pop && (group.count != '0);

    tuc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_unit  (code_unit),
        .pop        (pop),
        .item_valid (item_valid),
        .item_unit  (item_unit)
    );

    tuc_encoder u_enc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_unit  (item_unit),
        .q_free     (q_free),
        .pop        (pop),
        .group      (group)
    );

    tuc_out_queue u_oq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .group      (group),
        .q_free     (q_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .last       (last)
    );

endmodule

// ===== rtl/tuc_in_stage.sv =====
// ----------------------------------------------------------------------------
// tuc_in_stage
// Input register: holds one code unit until the encoder takes it.
// ----------------------------------------------------------------------------
module tuc_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tuc_pkg::UNIT_W-1:0]  code_unit,
    input  logic                        pop,
    output logic                        item_valid,
    output logic [tuc_pkg::UNIT_W-1:0]  item_unit
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [tuc_pkg::UNIT_W-1:0] unit_reg;
    logic                       take;

    assign in_ready   = !valid_reg || pop;
    assign take       = in_valid && in_ready;
    assign valid_next = take || (valid_reg && !pop);
    assign item_valid = valid_reg;
    assign item_unit  = unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            unit_reg <= code_unit;
    end

endmodule

// ===== rtl/tuc_encoder.sv =====
// ----------------------------------------------------------------------------
// tuc_encoder
// String state, configuration registers and the single-pass encode of one
// code unit into a group of up to six results.
// ----------------------------------------------------------------------------
module tuc_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [tuc_pkg::CAP_W-1:0]   cfg_data,
    input  logic                        item_valid,
    input  logic [tuc_pkg::UNIT_W-1:0]  item_unit,
    input  logic                        q_free,
    output logic                        pop,
    output tuc_pkg::tuc_group_t         group
);

    logic                        strict_reg;
    logic [tuc_pkg::CAP_W-1:0]   cap_reg;
    logic [9:0]                  held_reg;
    logic [9:0]                  held_next;
    logic                        held_valid_reg;
    logic                        held_valid_next;
    logic [tuc_pkg::BCNT_W-1:0]  bw_reg;
    logic [tuc_pkg::BCNT_W-1:0]  bw_next;
    logic                        stopped_reg;
    logic                        stopped_next;

    logic                        is_zero;
    logic                        is_hi;
    logic                        is_lo;
    logic                        take;
    logic                        a_emit;
    logic                        a_fits;
    logic                        b_emit;
    logic                        b_fits;
    logic                        b_stat;
    logic [2:0]                  b_status;
    logic [tuc_pkg::CP_W-1:0]    b_ch;
    logic [2:0]                  b_len;
    logic [3:0][7:0]             b_bytes;
    logic [3:0][7:0]             a_bytes;
    logic [tuc_pkg::BCNT_W-1:0]  cap_ext;
    logic [tuc_pkg::BCNT_W-1:0]  bw_base;
    logic [tuc_pkg::RCNT_W-1:0]  off;
    logic [tuc_pkg::RCNT_W-1:0]  slot;

    assign cap_ext = {1'b0, cap_reg};
    assign pop     = item_valid && (group.count == '0 || q_free);

    always_comb
    begin
        is_zero         = (item_unit == '0);
        is_hi           = (item_unit[15:10] == tuc_pkg::SUR_HIGH_TAG);
        is_lo           = (item_unit[15:10] == tuc_pkg::SUR_LOW_TAG);
        take            = 1'b0;
        a_emit          = 1'b0;
        b_emit          = 1'b0;
        b_stat          = 1'b0;
        b_status        = tuc_pkg::ST_RUNNING;
        b_ch            = '0;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        stopped_next    = stopped_reg;
        a_fits          = (bw_reg + 17'd3) <= cap_ext;
        a_bytes         = tuc_pkg::utf8_bytes({5'b0, tuc_pkg::SUR_HIGH_TAG, held_reg});

        if (is_zero)
        begin
            if (!stopped_reg)
            begin
                b_stat   = 1'b1;
                b_status = held_valid_reg ? tuc_pkg::ST_SRC_EXH : tuc_pkg::ST_DONE;
            end
            held_next       = '0;
            held_valid_next = 1'b0;
            stopped_next    = 1'b0;
        end
        else if (stopped_reg)
        begin
            take = 1'b0;
        end
        else if (held_valid_reg)
        begin
            held_next       = '0;
            held_valid_next = 1'b0;
            if (is_lo)
            begin
                b_emit = 1'b1;
                b_ch   = {1'b0, held_reg, item_unit[9:0]} + tuc_pkg::SUPP_BASE;
            end
            else if (strict_reg)
            begin
                b_stat   = 1'b1;
                b_status = tuc_pkg::ST_SRC_ILL;
            end
            else if (a_fits)
            begin
                a_emit = 1'b1;
                take   = 1'b1;
            end
            else
            begin
                b_stat   = 1'b1;
                b_status = tuc_pkg::ST_TGT_EXH;
            end
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            if (is_hi)
            begin
                held_next       = item_unit[9:0];
                held_valid_next = 1'b1;
            end
            else if (is_lo && strict_reg)
            begin
                b_stat   = 1'b1;
                b_status = tuc_pkg::ST_SRC_ILL;
            end
            else
            begin
                b_emit = 1'b1;
                b_ch   = {5'b0, item_unit};
            end
        end

        bw_base = a_emit ? (bw_reg + 17'd3) : bw_reg;
        b_len   = tuc_pkg::utf8_len(b_ch);
        b_bytes = tuc_pkg::utf8_bytes(b_ch);
        b_fits  = (bw_base + {14'b0, b_len}) <= cap_ext;

        if (b_emit && !b_fits)
        begin
            b_stat   = 1'b1;
            b_status = tuc_pkg::ST_TGT_EXH;
        end

        if (b_stat && !is_zero)
        begin
            stopped_next    = 1'b1;
            held_next       = '0;
            held_valid_next = 1'b0;
        end

        if (is_zero)
            bw_next = '0;
        else if (b_emit && b_fits)
            bw_next = bw_base + {14'b0, b_len};
        else
            bw_next = bw_base;

        // result group: held high surrogate bytes first, then this unit
        off         = a_emit ? 3'd3 : 3'd0;
        group.res   = '0;
        group.count = off;
        if (a_emit)
        begin
            for (int i = 0; i < 3; i++)
                group.res[i] = '{data: a_bytes[i], dvalid: 1'b1, status: tuc_pkg::ST_RUNNING};
        end
        slot = off;
        if (b_stat)
        begin
            group.res[slot] = '{data: 8'h00, dvalid: 1'b0, status: b_status};
            group.count     = off + 3'd1;
        end
        else if (b_emit)
        begin
            for (int j = 0; j < 4; j++)
            begin
                slot = off + 3'(j);
                if (3'(j) < b_len && slot < 3'(tuc_pkg::MAX_RES))
                    group.res[slot] = '{data: b_bytes[j], dvalid: 1'b1,
                                        status: tuc_pkg::ST_RUNNING};
            end
            group.count = off + b_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b1;
            cap_reg    <= 16'hFFFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tuc_pkg::CFG_STRICT:   strict_reg <= cfg_data[0];
                tuc_pkg::CFG_CAPACITY: cap_reg    <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            bw_reg         <= '0;
            stopped_reg    <= 1'b0;
        end
        else if (pop)
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            bw_reg         <= bw_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

// ===== rtl/tuc_out_queue.sv =====
// ----------------------------------------------------------------------------
// tuc_out_queue
// Result register: loads a whole group and shifts it out one result per
// request.
// ----------------------------------------------------------------------------
module tuc_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tuc_pkg::tuc_group_t group,
    output logic                q_free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic [2:0]          status,
    output logic                last
);

    tuc_pkg::tuc_res_t [tuc_pkg::MAX_RES-1:0] res_reg;
    tuc_pkg::tuc_res_t [tuc_pkg::MAX_RES-1:0] res_next;
    logic [tuc_pkg::RCNT_W-1:0]               cnt_reg;
    logic [tuc_pkg::RCNT_W-1:0]               cnt_next;
    logic                                     shift;

    assign out_valid  = (cnt_reg != '0);
    assign last       = (cnt_reg == 3'd1);
    assign shift      = out_valid && out_ready;
    assign q_free     = (cnt_reg == '0) || (last && out_ready);
    assign out_byte   = res_reg[0].data;
    assign byte_valid = res_reg[0].dvalid;
    assign status     = res_reg[0].status;

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = group.res;
            cnt_next = group.count;
        end
        else if (shift)
        begin
            for (int i = 0; i < tuc_pkg::MAX_RES - 1; i++)
                res_next[i] = res_reg[i+1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== rtl/tuc_checker.sv =====
// ----------------------------------------------------------------------------
// tuc_checker
// Port-level checks on the transcoder result stream.
// ----------------------------------------------------------------------------
module tuc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic [2:0]  status,
    input  logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
            && $stable(status) && $stable(last))
        else $error("result changed while stalled");

    a_data_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == tuc_pkg::ST_RUNNING)
        else $error("data byte with nonzero status");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && status != tuc_pkg::ST_RUNNING && out_byte == 8'h00)
        else $error("status result malformed or not last");

    a_group_contig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a result group");

endmodule

bind utf16_to_utf8_transcoder tuc_checker u_tuc_checker (.*);
